// File: hdl/rpwc_pkg.sv
package rpwc_pkg;

  localparam int unsigned DEF_PART_BITS    = 8;
  localparam int unsigned DEF_PAYLOAD_BITS = 32;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned ROW_ID_W    = 32;
  localparam int unsigned LINE_IDX_W  = 32;
  localparam int unsigned PART_OUT_W  = 8;
  localparam int unsigned LINE_WORDS  = 8;
  // The eighth word of a line is never stored: it arrives with the item that closes the line.
  localparam int unsigned STORE_BANKS = LINE_WORDS - 1;
  localparam int unsigned SLOT_W      = $clog2(LINE_WORDS);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LINE_WORDS - 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [LINE_IDX_W-1:0] lines;
    slot_t                 fill;
  } part_state_t;

endpackage

// File: hdl/rpwc_line_store.sv
module rpwc_line_store #(
  parameter int unsigned PartBits = rpwc_pkg::DEF_PART_BITS
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  rpwc_pkg::slot_t      wr_slot_i,
  input  logic [PartBits-1:0]  wr_addr_i,
  input  rpwc_pkg::word_t      wr_word_i,
  input  logic                 rd_en_i,
  input  logic [PartBits-1:0]  rd_addr_i,
  output rpwc_pkg::word_t      rd_words_o [rpwc_pkg::STORE_BANKS]
);
  import rpwc_pkg::*;

  localparam int unsigned NumParts = 1 << PartBits;

  // One bank per slot of a line; each bank is addressed by partition.
  for (genvar k = 0; k < STORE_BANKS; k++) begin : g_bank
    word_t mem [NumParts];
    word_t rd_q;

    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_slot_i == SLOT_W'(k))) begin
        mem[wr_addr_i] <= wr_word_i;
      end
      if (rd_en_i) begin
        rd_q <= mem[rd_addr_i];
      end
    end

    assign rd_words_o[k] = rd_q;
  end

endmodule

// File: hdl/radix_partition_write_combine_core.sv
// A line result enters the output register when its closing item leaves stage 1.
// Throughput: one item per cycle unless stalled; the per-partition state memory is read on
// input transfer and written as the item leaves stage 1, with a one-entry forward covering
// back-to-back partitions. A result held at the output stalls stage 1 and the input until
// it is taken. Reset: control state clears at once; then a clearing pass zeroes the state
// memory, and no input is taken until it ends. Line word storage is not cleared.
module radix_partition_write_combine_core #(
  parameter int unsigned PartBits    = rpwc_pkg::DEF_PART_BITS,
  parameter int unsigned PayloadBits = rpwc_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rpwc_pkg::word_t                     key_i,
  input  logic [rpwc_pkg::ROW_ID_W-1:0]       row_id_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rpwc_pkg::PART_OUT_W-1:0]     partition_o,
  output logic [rpwc_pkg::LINE_IDX_W-1:0]     line_index_o,
  output rpwc_pkg::word_t                     word_0_o,
  output rpwc_pkg::word_t                     word_1_o,
  output rpwc_pkg::word_t                     word_2_o,
  output rpwc_pkg::word_t                     word_3_o,
  output rpwc_pkg::word_t                     word_4_o,
  output rpwc_pkg::word_t                     word_5_o,
  output rpwc_pkg::word_t                     word_6_o,
  output rpwc_pkg::word_t                     word_7_o
);
  import rpwc_pkg::*;

  localparam int unsigned NumParts = 1 << PartBits;

  // Input transfer and stage 1 control.
  logic                in_xfer;
  logic                s1_go;
  logic                s1_fire;
  logic                s1_valid_q;
  logic [PartBits-1:0] s1_part_q;
  word_t               s1_word_q;
  logic [PartBits-1:0] in_part;
  word_t               key_hi;
  word_t               in_word;

  // Per-partition state memory.
  part_state_t         st_mem [NumParts];
  part_state_t         st_rd_q;
  part_state_t         st_cur;
  part_state_t         st_next;
  logic                st_we;
  logic [PartBits-1:0] st_waddr;
  part_state_t         st_wdata;

  // Forward of the write made at the edge the current stage 1 item was read.
  logic                fwd_valid_q;
  logic [PartBits-1:0] fwd_part_q;
  part_state_t         fwd_state_q;
  slot_t               fwd_slot_q;
  word_t               fwd_word_q;
  logic                fwd_hit;

  // Clearing pass.
  logic                clr_busy_q;
  logic [PartBits-1:0] clr_idx_q;

  // Line words.
  word_t               bank_rd [STORE_BANKS];
  word_t               line_w  [LINE_WORDS];
  slot_t               slot;
  logic                emit;

  // Output register.
  logic                  out_valid_q;
  logic [PART_OUT_W-1:0] out_part_q;
  logic [LINE_IDX_W-1:0] out_idx_q;
  word_t                 out_words_q [LINE_WORDS];

  assign s1_go      = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_go;
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || s1_go);
  assign in_xfer    = in_valid_i && in_ready_o;

  assign in_part = key_i[PartBits-1:0];
  assign key_hi  = (key_i >> PartBits) << (PartBits + PayloadBits);
  assign in_word = {{(WORD_W - ROW_ID_W){1'b0}}, row_id_i} + key_hi;

  assign fwd_hit = fwd_valid_q && (fwd_part_q == s1_part_q);
  assign st_cur  = fwd_hit ? fwd_state_q : st_rd_q;
  assign slot    = st_cur.fill;
  assign emit    = (slot == LAST_SLOT);

  always_comb begin
    st_next = st_cur;
    if (emit) begin
      st_next.lines = st_cur.lines + LINE_IDX_W'(1);
      st_next.fill  = '0;
    end else begin
      st_next.fill  = slot + SLOT_W'(1);
    end
  end

  // The line closes with all earlier slots written; the slot written at the same edge as
  // this item's read comes from the forward register.
  always_comb begin
    for (int k = 0; k < STORE_BANKS; k++) begin
      line_w[k] = (fwd_hit && (fwd_slot_q == SLOT_W'(k))) ? fwd_word_q : bank_rd[k];
    end
    line_w[LINE_WORDS-1] = s1_word_q;
  end

  assign st_we    = clr_busy_q || s1_fire;
  assign st_waddr = clr_busy_q ? clr_idx_q : s1_part_q;
  assign st_wdata = clr_busy_q ? '0 : st_next;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (in_xfer) begin
      st_rd_q <= st_mem[in_part];
    end
  end

  rpwc_line_store #(
    .PartBits (PartBits)
  ) u_line_store (
    .clk_i      (clk_i),
    .wr_en_i    (s1_fire && !emit),
    .wr_slot_i  (slot),
    .wr_addr_i  (s1_part_q),
    .wr_word_i  (s1_word_q),
    .rd_en_i    (in_xfer),
    .rd_addr_i  (in_part),
    .rd_words_o (bank_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + PartBits'(1);
        if (clr_idx_q == '1) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        fwd_valid_q <= 1'b1;
      end else if (in_xfer) begin
        fwd_valid_q <= 1'b0;
      end
      if (s1_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_part_q <= in_part;
      s1_word_q <= in_word;
    end
    if (s1_fire) begin
      fwd_part_q  <= s1_part_q;
      fwd_state_q <= st_next;
      fwd_slot_q  <= slot;
      fwd_word_q  <= s1_word_q;
    end
    if (s1_fire && emit) begin
      out_part_q  <= PART_OUT_W'(s1_part_q);
      out_idx_q   <= st_cur.lines;
      out_words_q <= line_w;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign partition_o  = out_part_q;
  assign line_index_o = out_idx_q;
  assign word_0_o     = out_words_q[0];
  assign word_1_o     = out_words_q[1];
  assign word_2_o     = out_words_q[2];
  assign word_3_o     = out_words_q[3];
  assign word_4_o     = out_words_q[4];
  assign word_5_o     = out_words_q[5];
  assign word_6_o     = out_words_q[6];
  assign word_7_o     = out_words_q[7];

`ifndef SYNTHESIS
  // No tuple may enter while the state memory is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni) clr_busy_q |-> !in_ready_o)
    else $error("input transfer allowed during clearing pass");

  // A stalled stage 1 item keeps its partition and its forward context.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |=> (s1_valid_q && $stable(s1_part_q) && $stable(fwd_valid_q)))
    else $error("stage 1 item changed while stalled");

  // A closed line always reaches the output register on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (s1_fire && emit) |=> out_valid_o)
    else $error("closed line did not reach the output");

  // Clearing and item processing never share the state write port.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(clr_busy_q && s1_valid_q))
    else $error("stage 1 active during clearing pass");
`endif

endmodule

// File: sim/tb_radix_partition_write_combine_core.sv
module tb_radix_partition_write_combine_core;
  import rpwc_pkg::*;

  localparam int unsigned PartBits    = DEF_PART_BITS;
  localparam int unsigned PayloadBits = DEF_PAYLOAD_BITS;
  localparam int unsigned NumParts    = 1 << PartBits;
  localparam int unsigned NumHot      = 6;

  typedef struct packed {
    logic [PART_OUT_W-1:0]             part;
    logic [LINE_IDX_W-1:0]             idx;
    logic [LINE_WORDS-1:0][WORD_W-1:0] words;
  } line_rec_t;

  typedef struct packed {
    word_t                 key;
    logic [ROW_ID_W-1:0]   row_id;
    bit                    typed;
    line_rec_t             line;
  } stim_row_t;

  typedef enum int {READY_RUN, READY_COIN, READY_STALL, READY_MOSTLY} ready_mode_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  out_ready_i = 1'b0;
  word_t                 key_i       = '0;
  logic [ROW_ID_W-1:0]   row_id_i    = '0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [PART_OUT_W-1:0] partition_o;
  logic [LINE_IDX_W-1:0] line_index_o;
  word_t word_0_o, word_1_o, word_2_o, word_3_o, word_4_o, word_5_o, word_6_o, word_7_o;

  // Shadow of the per-partition line buffers.
  word_t                 buf_words [NumParts][LINE_WORDS];
  slot_t                 buf_fill  [NumParts];
  logic [LINE_IDX_W-1:0] buf_lines [NumParts];

  line_rec_t   pending_lines[$];
  int unsigned lines_predicted = 0;
  int unsigned lines_checked   = 0;
  int unsigned mismatches      = 0;
  int unsigned burst_left      = 5;
  bit          hold_done       = 1'b0;

  radix_partition_write_combine_core #(
    .PartBits   (PartBits),
    .PayloadBits(PayloadBits)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .key_i       (key_i),
    .row_id_i    (row_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .partition_o (partition_o),
    .line_index_o(line_index_o),
    .word_0_o    (word_0_o),
    .word_1_o    (word_1_o),
    .word_2_o    (word_2_o),
    .word_3_o    (word_3_o),
    .word_4_o    (word_4_o),
    .word_5_o    (word_5_o),
    .word_6_o    (word_6_o),
    .word_7_o    (word_7_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  // Packs one tuple into its partition's line; returns 1 when that closes the line.
  function automatic bit append_tuple(input word_t key, input logic [ROW_ID_W-1:0] rid,
                                      output line_rec_t line);
    int unsigned p;
    word_t       tuple_w;
    slot_t       s;
    p       = int'(key & word_t'(NumParts - 1));
    tuple_w = word_t'(rid) + ((key >> PartBits) << (PartBits + PayloadBits));
    s       = buf_fill[p];
    buf_words[p][s] = tuple_w;
    line = '0;
    if (s != LAST_SLOT) begin
      buf_fill[p] = s + 1'b1;
      return 1'b0;
    end
    line.part = PART_OUT_W'(p);
    line.idx  = buf_lines[p];
    for (int k = 0; k < LINE_WORDS; k++) line.words[k] = buf_words[p][k];
    buf_fill[p]  = '0;
    buf_lines[p] = buf_lines[p] + 1'b1;
    return 1'b1;
  endfunction

  // Offers one tuple until it is transferred, then applies the burst and gap pacing.
  task automatic offer_tuple(input word_t key, input logic [ROW_ID_W-1:0] rid,
                             input bit typed, input line_rec_t typed_line);
    line_rec_t line;
    in_valid_i <= 1'b1;
    key_i      <= key;
    row_id_i   <= rid;
    do @(posedge clk_i); while (!in_ready_o);
    if (append_tuple(key, rid, line)) begin
      pending_lines.push_back(typed ? typed_line : line);
      lines_predicted++;
    end
    burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
  endtask

  initial begin
    stim_row_t             rows[$];
    stim_row_t             row;
    int unsigned           hot_parts[NumHot];
    int unsigned           n_random;
    int unsigned           roll;
    logic [PartBits-1:0]   part;
    logic [PartBits-1:0]   prev_part;
    word_t                 key;
    logic [ROW_ID_W-1:0]   rid;

    for (int p = 0; p < NumParts; p++) begin
      buf_fill[p]  = '0;
      buf_lines[p] = '0;
    end

    // Partition 0 filled back to back: the words come out in arrival order.
    for (int k = 0; k < LINE_WORDS; k++) begin
      row = '0;
      row.row_id = ROW_ID_W'(k);
      row.typed  = (k == LINE_WORDS - 1);
      for (int j = 0; j < LINE_WORDS; j++) row.line.words[j] = WORD_W'(j);
      rows.push_back(row);
    end
    // Alternating extremes on the top partition and a second line on partition 0.
    // The key bits shifted past bit 63 are lost and bits 32..39 stay clear.
    for (int k = 0; k < 2 * LINE_WORDS; k++) begin
      row = '0;
      if (k % 2 == 0) begin
        row.key    = '1;
        row.row_id = '1;
        row.typed  = (k == 2 * LINE_WORDS - 2);
        row.line.part = '1;
        for (int j = 0; j < LINE_WORDS; j++) row.line.words[j] = 64'hFFFF_FF00_FFFF_FFFF;
      end else begin
        row.key    = 64'hFFFF_FFFF_FFFF_FF00;
        row.typed  = (k == 2 * LINE_WORDS - 1);
        row.line.idx = 1;
        for (int j = 0; j < LINE_WORDS; j++) row.line.words[j] = 64'hFFFF_FF00_0000_0000;
      end
      rows.push_back(row);
    end

    hot_parts[0] = 0;
    hot_parts[1] = NumParts - 1;
    for (int k = 2; k < NumHot; k++) hot_parts[k] = $urandom_range(0, NumParts - 1);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) offer_tuple(rows[i].key, rows[i].row_id, rows[i].typed, rows[i].line);

    // Most tuples go to a small set of busy partitions so that lines actually fill.
    n_random  = 0;
    prev_part = '0;
    while ((n_random < 950 || lines_predicted < 60) && n_random < 4000) begin
      roll = $urandom_range(0, 99);
      if (roll < 55)      part = PartBits'(hot_parts[$urandom_range(0, NumHot - 1)]);
      else if (roll < 75) part = prev_part;
      else                part = PartBits'($urandom_range(0, NumParts - 1));
      key = {$urandom, $urandom};
      roll = $urandom_range(0, 9);
      if (roll == 0)      key = '1;
      else if (roll == 1) key = '0;
      key[PartBits-1:0] = part;
      rid = $urandom;
      roll = $urandom_range(0, 9);
      if (roll == 0)      rid = '1;
      else if (roll == 1) rid = '0;
      offer_tuple(key, rid, 1'b0, '0);
      n_random++;
      prev_part = part;
      if ($urandom_range(0, 99) < 3)
        hot_parts[$urandom_range(2, NumHot - 1)] = $urandom_range(0, NumParts - 1);
    end
    in_valid_i <= 1'b0;

    while (pending_lines.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: mixes full-rate runs, random stalls, and one long hold-off that backs up the block.
  initial begin
    ready_mode_t mode;
    int unsigned run;
    @(posedge clk_i);
    forever begin
      if (!hold_done && lines_checked >= 10) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      mode = ready_mode_t'($urandom_range(0, 3));
      case (mode)
        READY_RUN:   run = $urandom_range(20, 60);
        READY_STALL: run = $urandom_range(1, 10);
        default:     run = $urandom_range(5, 30);
      endcase
      for (int k = 0; k < run; k++) begin
        case (mode)
          READY_RUN:   out_ready_i <= 1'b1;
          READY_COIN:  out_ready_i <= 1'($urandom_range(0, 1));
          READY_STALL: out_ready_i <= 1'b0;
          default:     out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    line_rec_t                         want;
    logic [LINE_WORDS-1:0][WORD_W-1:0] got;
    if (out_valid_o && out_ready_i) begin
      got = {word_7_o, word_6_o, word_5_o, word_4_o, word_3_o, word_2_o, word_1_o, word_0_o};
      lines_checked++;
      if (pending_lines.size() == 0) begin
        mismatches++;
        $error("line with no tuple to account for it: partition %0d", partition_o);
      end else begin
        want = pending_lines.pop_front();
        if (partition_o !== want.part) begin
          mismatches++;
          $error("partition: expected %0d, got %0d", want.part, partition_o);
        end
        if (line_index_o !== want.idx) begin
          mismatches++;
          $error("line_index: expected %0d, got %0d", want.idx, line_index_o);
        end
        for (int k = 0; k < LINE_WORDS; k++) begin
          if (got[k] !== want.words[k]) begin
            mismatches++;
            $error("word_%0d: expected %h, got %h", k, want.words[k], got[k]);
          end
        end
      end
    end
  end

endmodule
